@@ hw/rtl/tspp_pkg.sv @@
// Shared constants, codes and types of the triangle strip point pusher.
// No dependencies; the interfaces and the top level import it.
package tspp_pkg;

  localparam int unsigned MAX_VERTICES_DEF = 256;
  localparam int unsigned COORD_WIDTH_DEF  = 16;

  localparam int unsigned OFFSET_W   = 16;  // offset registers, Q12.4
  localparam int unsigned CNT_W      = 9;   // vertex_count register
  localparam int unsigned IDX_W      = 8;   // vertex_index field
  localparam int unsigned TRI_W      = 8;   // hit_triangle field
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam int unsigned TRI_VERTS  = 3;

  // push scale 550/256, rounded to nearest
  localparam int unsigned PUSH_NUM   = 550;
  localparam int unsigned PUSH_NUM_W = 10;
  localparam int unsigned PUSH_SHIFT = 8;
  localparam int unsigned PUSH_ROUND = 128;

  typedef enum logic {
    ACT_LOAD = 1'b0,
    ACT_TEST = 1'b1
  } action_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_OFFSET_X     = 2'd0,
    REG_OFFSET_Y     = 2'd1,
    REG_VERTEX_COUNT = 2'd2
  } cfg_reg_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_PUSH,
    ST_EMIT
  } state_e;

endpackage

@@ hw/rtl/tspp_if.sv @@
// Handshake channels of the triangle strip point pusher: configuration,
// request and result. Depends on tspp_pkg.
interface tspp_cfg_if import tspp_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

interface tspp_req_if import tspp_pkg::*; #(
  parameter int unsigned COORD_WIDTH = COORD_WIDTH_DEF
) ();
  logic                          valid;
  logic                          ready;
  logic                          action;
  logic [IDX_W-1:0]              vertex_index;
  logic signed [COORD_WIDTH-1:0] coord_x;
  logic signed [COORD_WIDTH-1:0] coord_y;
  logic signed [COORD_WIDTH-1:0] push_dx;
  logic signed [COORD_WIDTH-1:0] push_dy;

  modport source (output valid, action, vertex_index, coord_x, coord_y, push_dx, push_dy,
                  input ready);
  modport sink   (input valid, action, vertex_index, coord_x, coord_y, push_dx, push_dy,
                  output ready);
endinterface

interface tspp_rsp_if import tspp_pkg::*; #(
  parameter int unsigned COORD_WIDTH = COORD_WIDTH_DEF
) ();
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] result_x;
  logic signed [COORD_WIDTH-1:0] result_y;
  logic                          was_pushed;
  logic [TRI_W-1:0]              hit_triangle;

  modport source (output valid, result_x, result_y, was_pushed, hit_triangle, input ready);
  modport sink   (input valid, result_x, result_y, was_pushed, hit_triangle, output ready);
endinterface

@@ hw/rtl/triangle_strip_point_pusher.sv @@
// Top level of the triangle strip point pusher: vertex store, strip walk
// pipeline, push arithmetic and result register. Depends on tspp_pkg, tspp_if.
//
//   channel  dir  modport  moves
//   cfg_i    in   sink     register write: index, data (always ready)
//   req_i    in   sink     request: load vertex or test point
//   rsp_o    out  source   result of a test request
//
// Sequence: a load request writes the store and leaves the block idle. A
// test request walks the strip reading one vertex per cycle from the
// single-port store, and stops early when a triangle hits: one read per
// vertex, three pipeline stages (offset, products, sign test), the push
// state on a hit and the emit state that loads the result register.
// Reset clears the configuration and control; the store has no reset and
// no clearing pass. A new request is taken while a result still waits; the
// test that follows it holds in its emit state until the result register frees.
module triangle_strip_point_pusher import tspp_pkg::*; #(
  parameter int unsigned MAX_VERTICES = MAX_VERTICES_DEF,
  parameter int unsigned COORD_WIDTH  = COORD_WIDTH_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  tspp_cfg_if.sink        cfg_i,
  tspp_req_if.sink        req_i,
  tspp_rsp_if.source      rsp_o
);

  localparam int unsigned CW   = COORD_WIDTH;
  localparam int unsigned AW   = $clog2(MAX_VERTICES);
  localparam int unsigned IW   = ($clog2(MAX_VERTICES + 1) > CNT_W) ?
                                 $clog2(MAX_VERTICES + 1) : CNT_W;
  localparam int unsigned PW   = ((CW > OFFSET_W) ? CW : OFFSET_W) + 1; // placed vertex
  localparam int unsigned DW   = PW + 1;                                // edge vector
  localparam int unsigned PRW  = 2 * DW;                                // product
  localparam int unsigned DFW  = PRW + 1;                               // cross product
  localparam int unsigned MULW = CW + PUSH_NUM_W + 1;
  localparam int unsigned MAGW = CW + 3;
  localparam int unsigned SW   = CW + 4;
  localparam int unsigned SUMW = CW + 5;

  localparam logic signed [SUMW-1:0] SAT_HI = SUMW'((longint'(1) << (CW - 1)) - 1);
  localparam logic signed [SUMW-1:0] SAT_LO = -SAT_HI - SUMW'(1);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic signed [OFFSET_W-1:0] offset_x_q, offset_y_q;
  logic [CNT_W-1:0]           vertex_count_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_x_q     <= '0;
      offset_y_q     <= '0;
      vertex_count_q <= '0;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        REG_OFFSET_X:     offset_x_q     <= OFFSET_W'(cfg_i.data);
        REG_OFFSET_Y:     offset_y_q     <= OFFSET_W'(cfg_i.data);
        REG_VERTEX_COUNT: vertex_count_q <= cfg_i.data[CNT_W-1:0];
        default: ;  // unused index: drop the write
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Control
  // ---------------------------------------------------------------------------
  state_e state_q, state_d;

  logic req_fire, test_start, load_fire;
  logic rd_en, pipe_run, walk_done, out_free, out_load;
  logic short_strip, tri_hit, last_tri;

  logic [IW-1:0] n_q, n_d;
  logic [IW-1:0] rd_idx_q;     // next vertex to read
  logic [IW-1:0] recv_q;       // vertices that reached the window
  logic [IW-1:0] tri_c_q;      // triangle at the sign test stage
  logic          rv_q, av_q, bv_q;
  logic          hit_q;
  logic [IW-1:0] tri_q;

  assign req_i.ready = (state_q == ST_IDLE);
  assign req_fire    = req_i.valid && req_i.ready;
  assign test_start  = req_fire && (req_i.action == ACT_TEST);
  assign load_fire   = req_fire && (req_i.action == ACT_LOAD);

  assign n_d = (IW'(vertex_count_q) > IW'(MAX_VERTICES)) ? IW'(MAX_VERTICES)
                                                          : IW'(vertex_count_q);

  assign short_strip = (n_q < IW'(TRI_VERTS));
  assign last_tri    = (tri_c_q + IW'(TRI_VERTS) == n_q);
  assign out_free    = !rsp_o.valid || rsp_o.ready;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (test_start) state_d = ST_WALK;
      ST_WALK: if (walk_done)  state_d = (bv_q && tri_hit) ? ST_PUSH : ST_EMIT;
      ST_PUSH: state_d = ST_EMIT;
      ST_EMIT: if (out_free)   state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    walk_done = 1'b0;
    rd_en     = 1'b0;
    out_load  = 1'b0;
    unique case (state_q)
      ST_WALK: begin
        walk_done = short_strip || (bv_q && (tri_hit || last_tri));
        rd_en     = (rd_idx_q < n_q);
      end
      ST_EMIT: out_load = out_free;
      default: ;
    endcase
  end

  // stop feeding the pipeline once the walk has an answer
  assign pipe_run = (state_q == ST_WALK) && !walk_done;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      rd_idx_q <= '0;
      recv_q   <= '0;
      tri_c_q  <= '0;
      rv_q     <= 1'b0;
      av_q     <= 1'b0;
      bv_q     <= 1'b0;
    end else begin
      state_q <= state_d;
      rv_q    <= rd_en && pipe_run;
      av_q    <= rv_q && pipe_run && (recv_q >= IW'(TRI_VERTS - 1));
      bv_q    <= av_q && pipe_run;
      if (test_start) begin
        rd_idx_q <= '0;
        recv_q   <= '0;
        tri_c_q  <= '0;
      end else begin
        if (rd_en && pipe_run) rd_idx_q <= rd_idx_q + IW'(1);
        if (rv_q)              recv_q   <= recv_q + IW'(1);
        if (bv_q)              tri_c_q  <= tri_c_q + IW'(1);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Request payload held for the walk
  // ---------------------------------------------------------------------------
  logic signed [CW-1:0] q_x_q, q_y_q, dx_q, dy_q;

  always_ff @(posedge clk_i) begin
    if (test_start) begin
      q_x_q <= req_i.coord_x;
      q_y_q <= req_i.coord_y;
      dx_q  <= req_i.push_dx;
      dy_q  <= req_i.push_dy;
      n_q   <= n_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Vertex store: written by loads in idle, read only while walking, so the
  // two never touch the same cycle and need no forwarding
  // ---------------------------------------------------------------------------
  logic [2*CW-1:0] mem [MAX_VERTICES];
  logic [2*CW-1:0] rdata_q;
  logic [IW-1:0]   wr_idx;

  assign wr_idx = IW'(req_i.vertex_index);

  always_ff @(posedge clk_i) begin
    if (load_fire && (wr_idx < IW'(MAX_VERTICES))) begin
      mem[wr_idx[AW-1:0]] <= {req_i.coord_x, req_i.coord_y};
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) rdata_q <= mem[rd_idx_q[AW-1:0]];
  end

  // ---------------------------------------------------------------------------
  // Stage A: offset the vertex and shift it into the three-vertex window
  // ---------------------------------------------------------------------------
  logic signed [CW-1:0] rd_x, rd_y;
  logic signed [PW-1:0] w_x_q [TRI_VERTS];
  logic signed [PW-1:0] w_y_q [TRI_VERTS];

  assign rd_x = rdata_q[2*CW-1:CW];
  assign rd_y = rdata_q[CW-1:0];

  always_ff @(posedge clk_i) begin
    if (rv_q) begin
      w_x_q[0] <= w_x_q[1];
      w_y_q[0] <= w_y_q[1];
      w_x_q[1] <= w_x_q[2];
      w_y_q[1] <= w_y_q[2];
      w_x_q[2] <= PW'(rd_x) + PW'(offset_x_q);
      w_y_q[2] <= PW'(rd_y) + PW'(offset_y_q);
    end
  end

  // ---------------------------------------------------------------------------
  // Stage B: edge vectors and the eight products of the four orientations
  //   0: (p0, p1, p2)  triangle area
  //   1: (q, p1, p2)   2: (q, p2, p0)   3: (q, p0, p1)
  // ---------------------------------------------------------------------------
  logic signed [PW-1:0]  o_x [4], o_y [4], a_x [4], a_y [4], b_x [4], b_y [4];
  logic signed [DW-1:0]  e_ax [4], e_ay [4], e_bx [4], e_by [4];
  logic signed [PRW-1:0] prod_l_q [4], prod_r_q [4];
  logic signed [PW-1:0]  qp_x, qp_y;

  assign qp_x = PW'(q_x_q);
  assign qp_y = PW'(q_y_q);

  assign o_x[0] = w_x_q[0]; assign o_y[0] = w_y_q[0];
  assign a_x[0] = w_x_q[1]; assign a_y[0] = w_y_q[1];
  assign b_x[0] = w_x_q[2]; assign b_y[0] = w_y_q[2];

  assign o_x[1] = qp_x;     assign o_y[1] = qp_y;
  assign a_x[1] = w_x_q[1]; assign a_y[1] = w_y_q[1];
  assign b_x[1] = w_x_q[2]; assign b_y[1] = w_y_q[2];

  assign o_x[2] = qp_x;     assign o_y[2] = qp_y;
  assign a_x[2] = w_x_q[2]; assign a_y[2] = w_y_q[2];
  assign b_x[2] = w_x_q[0]; assign b_y[2] = w_y_q[0];

  assign o_x[3] = qp_x;     assign o_y[3] = qp_y;
  assign a_x[3] = w_x_q[0]; assign a_y[3] = w_y_q[0];
  assign b_x[3] = w_x_q[1]; assign b_y[3] = w_y_q[1];

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      e_ax[k] = DW'(a_x[k]) - DW'(o_x[k]);
      e_ay[k] = DW'(a_y[k]) - DW'(o_y[k]);
      e_bx[k] = DW'(b_x[k]) - DW'(o_x[k]);
      e_by[k] = DW'(b_y[k]) - DW'(o_y[k]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (av_q) begin
      for (int k = 0; k < 4; k++) begin
        prod_l_q[k] <= PRW'(e_ax[k]) * PRW'(e_by[k]);
        prod_r_q[k] <= PRW'(e_bx[k]) * PRW'(e_ay[k]);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage C: signs of the cross products; a zero-area triangle never hits,
  // a zero sub-area counts as inside
  // ---------------------------------------------------------------------------
  logic signed [DFW-1:0] xprod [4];
  logic [3:0]            neg, pos;

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      xprod[k] = DFW'(prod_l_q[k]) - DFW'(prod_r_q[k]);
      neg[k]   = xprod[k][DFW-1];
      pos[k]   = !neg[k] && (xprod[k] != '0);
    end
    tri_hit = (neg[0] || pos[0]) &&
              (pos[0] ? !(neg[1] || neg[2] || neg[3])
                      : !(pos[1] || pos[2] || pos[3]));
  end

  always_ff @(posedge clk_i) begin
    if (walk_done) begin
      hit_q <= bv_q && tri_hit;
      tri_q <= (bv_q && tri_hit) ? tri_c_q : '0;
    end
  end

  // ---------------------------------------------------------------------------
  // Push: magnitude of push * 550 / 256, rounded, then signed add and clamp
  // ---------------------------------------------------------------------------
  logic [CW-1:0]          abs_x, abs_y;
  logic [MAGW-1:0]        mag_x_q, mag_y_q;
  logic signed [SW-1:0]   step_x, step_y;
  logic signed [SUMW-1:0] sum_x, sum_y;
  logic signed [CW-1:0]   res_x, res_y;

  assign abs_x = dx_q[CW-1] ? CW'(-dx_q) : CW'(dx_q);
  assign abs_y = dy_q[CW-1] ? CW'(-dy_q) : CW'(dy_q);

  always_ff @(posedge clk_i) begin
    if (state_q == ST_PUSH) begin
      mag_x_q <= MAGW'((MULW'(abs_x) * MULW'(PUSH_NUM) + MULW'(PUSH_ROUND)) >> PUSH_SHIFT);
      mag_y_q <= MAGW'((MULW'(abs_y) * MULW'(PUSH_NUM) + MULW'(PUSH_ROUND)) >> PUSH_SHIFT);
    end
  end

  assign step_x = dx_q[CW-1] ? -SW'(mag_x_q) : SW'(mag_x_q);
  assign step_y = dy_q[CW-1] ? -SW'(mag_y_q) : SW'(mag_y_q);
  assign sum_x  = SUMW'(q_x_q) + SUMW'(step_x);
  assign sum_y  = SUMW'(q_y_q) + SUMW'(step_y);

  always_comb begin
    if (sum_x > SAT_HI)      res_x = CW'(SAT_HI);
    else if (sum_x < SAT_LO) res_x = CW'(SAT_LO);
    else                     res_x = CW'(sum_x);
    if (sum_y > SAT_HI)      res_y = CW'(SAT_HI);
    else if (sum_y < SAT_LO) res_y = CW'(SAT_LO);
    else                     res_y = CW'(sum_y);
  end

  // ---------------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------------
  logic rsp_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (out_load) begin
      rsp_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      rsp_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      rsp_o.result_x     <= hit_q ? res_x : q_x_q;
      rsp_o.result_y     <= hit_q ? res_y : q_y_q;
      rsp_o.was_pushed   <= hit_q;
      rsp_o.hit_triangle <= tri_q[TRI_W-1:0];
    end
  end

  assign rsp_o.valid = rsp_valid_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_pipe_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_WALK) |-> !(rv_q || av_q || bv_q))
    else $error("walk pipeline active outside a walk");

  a_window_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bv_q |-> (recv_q >= IW'(TRI_VERTS)))
    else $error("triangle tested before three vertices arrived");

  a_tri_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bv_q |-> (tri_c_q + IW'(TRI_VERTS) <= n_q))
    else $error("triangle index beyond the strip");

  a_rsp_from_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rsp_valid_q) |-> ($past(state_q) == ST_EMIT))
    else $error("result raised outside the emit state");

endmodule
